### src/stl_pkg.sv
// Shared types and constants for the source text lexer.
// Token kind codes, token and queue entry structs, stream widths.
// No dependencies.
package stl_pkg;

    // default width of the position and length counters
    localparam int POSITION_BITS_DEF = 16;

    // widths of the result fields
    localparam int KIND_W  = 5;
    localparam int FIELD_W = 16;

    // result stream data width: kind, pos, len packed, padded to whole bytes
    localparam int TOKEN_W     = KIND_W + 2 * FIELD_W;
    localparam int TDATA_W     = ((TOKEN_W + 7) / 8) * 8;
    localparam int TDATA_PAD_W = TDATA_W - TOKEN_W;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // token kind codes
    localparam logic [KIND_W-1:0] K_LET    = 5'd0;
    localparam logic [KIND_W-1:0] K_RET    = 5'd1;
    localparam logic [KIND_W-1:0] K_FUN    = 5'd2;
    localparam logic [KIND_W-1:0] K_EQUAL  = 5'd3;
    localparam logic [KIND_W-1:0] K_NOTEQ  = 5'd4;
    localparam logic [KIND_W-1:0] K_LTEQ   = 5'd5;
    localparam logic [KIND_W-1:0] K_GTEQ   = 5'd6;
    localparam logic [KIND_W-1:0] K_LT     = 5'd7;
    localparam logic [KIND_W-1:0] K_GT     = 5'd8;
    localparam logic [KIND_W-1:0] K_ASSIGN = 5'd9;
    localparam logic [KIND_W-1:0] K_PLUS   = 5'd10;
    localparam logic [KIND_W-1:0] K_MINUS  = 5'd11;
    localparam logic [KIND_W-1:0] K_STAR   = 5'd12;
    localparam logic [KIND_W-1:0] K_SLASH  = 5'd13;
    localparam logic [KIND_W-1:0] K_LPAREN = 5'd14;
    localparam logic [KIND_W-1:0] K_RPAREN = 5'd15;
    localparam logic [KIND_W-1:0] K_LBRACK = 5'd16;
    localparam logic [KIND_W-1:0] K_RBRACK = 5'd17;
    localparam logic [KIND_W-1:0] K_LBRACE = 5'd18;
    localparam logic [KIND_W-1:0] K_RBRACE = 5'd19;
    localparam logic [KIND_W-1:0] K_SEMI   = 5'd20;
    localparam logic [KIND_W-1:0] K_COMMA  = 5'd21;
    localparam logic [KIND_W-1:0] K_NUM    = 5'd22;
    localparam logic [KIND_W-1:0] K_IDENT  = 5'd23;
    localparam logic [KIND_W-1:0] K_END    = 5'd24;
    localparam logic [KIND_W-1:0] K_ERROR  = 5'd25;

    // one token as it leaves the block
    typedef struct packed {
        logic [FIELD_W-1:0] len;
        logic [FIELD_W-1:0] pos;
        logic [KIND_W-1:0]  kind;
    } token_t;

    // all tokens caused by one input item
    typedef struct packed {
        logic   two;
        token_t second;
        token_t first;
    } entry_t;

endpackage

### src/stl_front.sv
// Front part of the lexer: scanner state, byte classification, token forming.
// Produces one queue entry per input item that causes tokens.
// Depends on stl_pkg.
module stl_front import stl_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_accept,
    input  logic [7:0]   in_byte,
    output logic         push,
    output entry_t       push_data
);

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_WORD, MODE_NUM, MODE_LT, MODE_GT, MODE_EQ, MODE_BANG
    } mode_t;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] KEY_LEN = POSITION_BITS'(3);
    localparam logic [POSITION_BITS-1:0] ONE     = POSITION_BITS'(1);

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [POSITION_BITS-1:0] length_reg, length_next;
    logic [23:0]              pend_reg, pend_next;
    logic                     err_reg, err_next;

    logic   fresh;
    logic   ended;
    logic   is_alpha, is_dig, is_space;
    logic   e0_valid, e1_valid;
    token_t e0, e1;
    logic [KIND_W-1:0] word_kind, two_kind, one_kind, sk_kind;
    logic   sk_valid;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + ONE;
    endfunction

    // counter value as a 16-bit field: low bits, zero filled
    function automatic logic [FIELD_W-1:0] to_field(input logic [POSITION_BITS-1:0] v);
        logic [POSITION_BITS+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, v};
        return w[FIELD_W-1:0];
    endfunction

    // byte classes
    assign is_alpha = (in_byte >= "a" && in_byte <= "z") || (in_byte >= "A" && in_byte <= "Z");
    assign is_dig   = (in_byte >= "0" && in_byte <= "9");
    assign is_space = (in_byte == " ") || (in_byte == 8'h09) || (in_byte == 8'h0d)
                   || (in_byte == 8'h0a);

    // single character operators and punctuation
    always_comb begin
        sk_valid = 1'b1;
        case (in_byte)
            "+": sk_kind = K_PLUS;
            "-": sk_kind = K_MINUS;
            "*": sk_kind = K_STAR;
            "/": sk_kind = K_SLASH;
            "(": sk_kind = K_LPAREN;
            ")": sk_kind = K_RPAREN;
            "[": sk_kind = K_LBRACK;
            "]": sk_kind = K_RBRACK;
            "{": sk_kind = K_LBRACE;
            "}": sk_kind = K_RBRACE;
            ";": sk_kind = K_SEMI;
            ",": sk_kind = K_COMMA;
            default: begin
                sk_kind  = K_ERROR;
                sk_valid = 1'b0;
            end
        endcase
    end

    // keyword check, first three letters stored lowest byte first
    always_comb begin
        word_kind = K_IDENT;
        if (length_reg == KEY_LEN) begin
            if (pend_reg == {"t", "e", "l"})      word_kind = K_LET;
            else if (pend_reg == {"t", "e", "r"}) word_kind = K_RET;
            else if (pend_reg == {"n", "u", "f"}) word_kind = K_FUN;
        end
    end

    // kinds of a pending comparison operator, with or without a trailing '='
    always_comb begin
        case (mode_reg)
            MODE_LT: begin
                two_kind = K_LTEQ;
                one_kind = K_LT;
            end
            MODE_GT: begin
                two_kind = K_GTEQ;
                one_kind = K_GT;
            end
            MODE_EQ: begin
                two_kind = K_EQUAL;
                one_kind = K_ASSIGN;
            end
            default: begin
                two_kind = K_NOTEQ;
                one_kind = K_ERROR;
            end
        endcase
    end

    // scanner step: close a pending token, then handle the byte itself
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        length_next = length_reg;
        pend_next   = pend_reg;
        err_next    = err_reg;
        fresh       = 1'b1;
        ended       = 1'b0;
        e0_valid    = 1'b0;
        e0          = '0;
        e1_valid    = 1'b0;
        e1          = '0;

        // pending token
        if (!err_reg) begin
            case (mode_reg)
                MODE_WORD: begin
                    if (is_alpha || is_dig) begin
                        if (length_reg < KEY_LEN)
                            pend_next = pend_reg
                                | (24'(in_byte) << {length_reg[1:0], 3'b000});
                        length_next = sat_inc(length_reg);
                        fresh = 1'b0;
                    end else begin
                        e0_valid = 1'b1;
                        e0 = '{len: to_field(length_reg), pos: to_field(start_reg),
                               kind: word_kind};
                        mode_next   = MODE_IDLE;
                        start_next  = '0;
                        length_next = '0;
                        pend_next   = '0;
                    end
                end
                MODE_NUM: begin
                    if (is_dig) begin
                        length_next = sat_inc(length_reg);
                        fresh = 1'b0;
                    end else begin
                        e0_valid = 1'b1;
                        e0 = '{len: to_field(length_reg), pos: to_field(start_reg),
                               kind: K_NUM};
                        mode_next   = MODE_IDLE;
                        start_next  = '0;
                        length_next = '0;
                        pend_next   = '0;
                    end
                end
                MODE_LT, MODE_GT, MODE_EQ, MODE_BANG: begin
                    e0_valid = 1'b1;
                    if (in_byte == "=") begin
                        e0 = '{len: FIELD_W'(2), pos: to_field(start_reg), kind: two_kind};
                        fresh = 1'b0;
                    end else begin
                        e0 = '{len: FIELD_W'(1), pos: to_field(start_reg), kind: one_kind};
                        if (mode_reg == MODE_BANG) err_next = 1'b1;
                    end
                    mode_next   = MODE_IDLE;
                    start_next  = '0;
                    length_next = '0;
                    pend_next   = '0;
                end
                default: ;
            endcase
        end

        // the byte starts something new
        if (fresh) begin
            if (in_byte == 8'h00) begin
                e1_valid = 1'b1;
                e1 = '{len: FIELD_W'(1), pos: to_field(pos_reg), kind: K_END};
                ended = 1'b1;
            end else if (err_next) begin
                // discarded under error hold
            end else if (is_space) begin
                // whitespace
            end else if (is_alpha) begin
                mode_next   = MODE_WORD;
                start_next  = pos_reg;
                length_next = ONE;
                pend_next   = 24'(in_byte);
            end else if (is_dig) begin
                mode_next   = MODE_NUM;
                start_next  = pos_reg;
                length_next = ONE;
            end else if (in_byte == "<" || in_byte == ">" || in_byte == "=" || in_byte == "!")
            begin
                mode_next = (in_byte == "<") ? MODE_LT : (in_byte == ">") ? MODE_GT
                          : (in_byte == "=") ? MODE_EQ : MODE_BANG;
                start_next  = pos_reg;
                length_next = ONE;
            end else if (sk_valid) begin
                e1_valid = 1'b1;
                e1 = '{len: FIELD_W'(1), pos: to_field(pos_reg), kind: sk_kind};
            end else begin
                e1_valid = 1'b1;
                e1 = '{len: FIELD_W'(1), pos: to_field(pos_reg), kind: K_ERROR};
                err_next = 1'b1;
            end
        end

        // end of text returns everything to reset
        if (ended) begin
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            start_next  = '0;
            length_next = '0;
            pend_next   = '0;
            err_next    = 1'b0;
        end else begin
            pos_next = sat_inc(pos_reg);
        end
    end

    // queue entry for this item
    always_comb begin
        push               = in_accept && (e0_valid || e1_valid);
        push_data.first    = e0_valid ? e0 : e1;
        push_data.second   = e1;
        push_data.two      = e0_valid && e1_valid;
    end

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            length_reg <= '0;
            pend_reg   <= '0;
            err_reg    <= 1'b0;
        end else if (in_accept) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            pend_reg   <= pend_next;
            err_reg    <= err_next;
        end
    end

endmodule

### src/stl_queue.sv
// Short queue of token entries between lexer front and back.
// Flip-flop storage, head read at the read pointer.
// Depends on stl_pkg.
module stl_queue import stl_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_data,
    input  logic   pop,
    output entry_t head,
    output logic   empty,
    output logic   full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    entry_t           store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign head  = store_reg[rd_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == DEPTH_CNT);

    // pointer and fill count update
    always_comb begin
        wr_next  = push ? ((wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? ((rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)      cnt_next = cnt_reg + 1'b1;
        else if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) store_reg[wr_reg] <= push_data;
    end

endmodule

### src/stl_back.sv
// Back part of the lexer: splits queue entries into single tokens
// and drives the registered result stream. Depends on stl_pkg.
module stl_back import stl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  entry_t             head,
    input  logic               empty,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    logic               valid_reg, valid_next;
    logic               half_reg, half_next;
    logic [TDATA_W-1:0] data_reg;
    logic               last_reg;
    logic               load;
    logic               is_last;
    token_t             tok;

    // pick the next token of the head entry
    always_comb begin
        tok     = half_reg ? head.second : head.first;
        is_last = half_reg || !head.two;
        load    = !empty && (!valid_reg || m_tready);
        pop     = load && is_last;
        half_next  = load ? !is_last : half_reg;
        valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {{TDATA_PAD_W{1'b0}}, tok.len, tok.pos, tok.kind};
            last_reg <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

### src/source_text_lexer_top.sv
// Streaming lexer: one source byte per item in, tokens out (kind, start offset, length).
// A byte is taken in every cycle while the 4-entry token queue has room; each byte
// causes zero, one or two tokens, and the output register sends one token a cycle while
// m_tready is high, so a byte that closes a pending token and also emits one of its own
// sends its two tokens one after the other. The first token of a byte is written to the
// token queue and then loaded into the output register. Words, numbers and < > = !
// are reported when the following byte arrives; a zero byte ends the text, flushes
// any pending token, emits an end token and restarts offsets at zero.
// Depends on stl_pkg, stl_front, stl_queue, stl_back.
module source_text_lexer_top import stl_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] char_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [4:0] token_kind, [20:5] token_pos,
                                          // [36:21] token_len, rest zero
    output logic               m_tlast    // last_of_run
);

    logic   q_push, q_pop, q_empty, q_full;
    entry_t q_in, q_head;
    logic   in_accept;

    // input item taken while the queue has room
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    stl_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .push      (q_push),
        .push_data (q_in)
    );

    stl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    stl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // an end token always closes the run of its byte
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4:0] == K_END) |-> m_tlast)
        else $error("end token not marked last");

    // end and error tokens are one byte long
    a_one_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[4:0] == K_END || m_tdata[4:0] == K_ERROR))
        |-> (m_tdata[36:21] == 16'd1))
        else $error("end or error token with length other than one");

    // no kind code beyond the error code and no stray padding bits
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:0] <= K_ERROR && m_tdata[TDATA_W-1:TOKEN_W] == '0))
        else $error("bad token kind or padding");

    // the queue never takes an entry while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("token queue overflow");
`endif

endmodule
